// ===== rtl/wpk_pkg.sv =====
// ----------------------------------------------------------------------------
// wpk_pkg
// Shared types and constants for the pixel wire packer.
// ----------------------------------------------------------------------------
`default_nettype none

package wpk_pkg;

  // Wire format codes
  localparam logic [1:0] FMT_RGB565 = 2'd0;
  localparam logic [1:0] FMT_BGR    = 2'd1;
  localparam logic [1:0] FMT_RGB    = 2'd2;
  localparam logic [1:0] FMT_XRGB   = 2'd3;

  // Word geometry
  localparam int unsigned WORD_BYTES = 8;
  localparam int unsigned HALF_BITS  = 32;

  // Result queue geometry
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // One result item
  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  byte_count;
    logic        last;
  } wpk_result_t;

  // Results produced by one pixel transfer
  typedef struct packed {
    logic        push_full;
    logic        push_part;
    wpk_result_t full;
    wpk_result_t part;
  } wpk_push_t;

endpackage

`default_nettype wire

// ===== rtl/wpk_encode.sv =====
// ----------------------------------------------------------------------------
// wpk_encode
// Converts one XRGB8888 pixel into its wire bytes, low byte first.
// ----------------------------------------------------------------------------
`default_nettype none

module wpk_encode (
  input  wire logic [31:0] pixel,
  input  wire logic [1:0]  wire_format,
  output logic      [31:0] bytes,
  output logic      [2:0]  nbytes
);

  logic [7:0] r;
  logic [7:0] g;
  logic [7:0] b;

  assign r = pixel[23:16];
  assign g = pixel[15:8];
  assign b = pixel[7:0];

  // Per-format byte layout
  always_comb begin
    case (wire_format)
      wpk_pkg::FMT_RGB565: begin
        bytes  = {16'h0000, r[7:3], g[7:2], b[7:3]};
        nbytes = 3'd2;
      end
      wpk_pkg::FMT_BGR: begin
        bytes  = {8'h00, r, g, b};
        nbytes = 3'd3;
      end
      wpk_pkg::FMT_RGB: begin
        bytes  = {8'h00, b, g, r};
        nbytes = 3'd3;
      end
      default: begin
        bytes  = pixel;
        nbytes = 3'd4;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/wpk_pack.sv =====
// ----------------------------------------------------------------------------
// wpk_pack
// Holds the pending bytes, merges each pixel in and forms up to two results.
// ----------------------------------------------------------------------------
`default_nettype none

module wpk_pack (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire logic [31:0]         bytes,
  input  wire logic [2:0]          nbytes,
  input  wire logic                end_of_frame,
  output wpk_pkg::wpk_push_t       push
);

  logic [55:0] pending_bytes;
  logic [2:0]  pending_count;

  logic [5:0]  shift;
  logic [95:0] merged;
  logic [63:0] lo;
  logic [63:0] hi;
  logic [3:0]  total;
  logic        full;
  logic [3:0]  rem;
  logic [63:0] rem_data;

  // Merge new bytes above the pending ones; pending bits above the count are zero
  assign shift  = {pending_count, 3'b000};
  assign merged = {40'h0, pending_bytes} | ({64'h0, bytes} << shift);
  assign lo     = merged[63:0];
  assign hi     = {32'h0, merged[95:64]};
  assign total  = {1'b0, pending_count} + {1'b0, nbytes};
  assign full   = total[3];
  assign rem    = {1'b0, total[2:0]};
  assign rem_data = full ? hi : lo;

  // Full word goes out with halves swapped, the partial one as is
  always_comb begin
    push.push_full       = full;
    push.full.word       = {lo[wpk_pkg::HALF_BITS-1:0], lo[63:wpk_pkg::HALF_BITS]};
    push.full.byte_count = 4'(wpk_pkg::WORD_BYTES);
    push.full.last       = end_of_frame && (rem == 4'd0);
    push.push_part       = end_of_frame && (rem != 4'd0);
    push.part.word       = rem_data;
    push.part.byte_count = rem;
    push.part.last       = 1'b1;
  end

  // Pending state, emptied at end of frame
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bytes <= '0;
      pending_count <= '0;
    end else if (accept) begin
      if (end_of_frame) begin
        pending_bytes <= '0;
        pending_count <= '0;
      end else begin
        pending_bytes <= rem_data[55:0];
        pending_count <= rem[2:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wpk_outq.sv =====
// ----------------------------------------------------------------------------
// wpk_outq
// Small result queue: takes up to two results per cycle, gives one per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wpk_outq (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire wpk_pkg::wpk_push_t  push,
  output logic                     room,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output wpk_pkg::wpk_result_t     head
);

  wpk_pkg::wpk_result_t entries [wpk_pkg::QDEPTH];

  logic [wpk_pkg::QPTR_W-1:0] wr_ptr;
  logic [wpk_pkg::QPTR_W-1:0] rd_ptr;
  logic [wpk_pkg::QCNT_W-1:0] count;
  logic [wpk_pkg::QPTR_W-1:0] wr_ptr_next;
  logic [wpk_pkg::QPTR_W-1:0] wr_ptr_second;
  logic [wpk_pkg::QCNT_W-1:0] count_next;

  logic                 push_first;
  logic                 push_second;
  logic [1:0]           npush;
  logic                 pop;
  wpk_pkg::wpk_result_t first;

  // Room means three or more free slots; the worst pixel needs two
  assign room      = count <= wpk_pkg::QCNT_W'(1);
  assign out_valid = count != '0;
  assign head      = entries[rd_ptr];
  assign pop       = out_valid && out_ready;

  assign push_first    = accept && (push.push_full || push.push_part);
  assign push_second   = accept && push.push_full && push.push_part;
  assign first         = push.push_full ? push.full : push.part;
  assign npush         = {1'b0, push_first} + {1'b0, push_second};
  assign wr_ptr_second = wr_ptr + 1'b1;
  assign wr_ptr_next   = wr_ptr + wpk_pkg::QPTR_W'(npush);
  assign count_next    = count + wpk_pkg::QCNT_W'(npush) - wpk_pkg::QCNT_W'(pop);

  // Entry storage
  always_ff @(posedge clk) begin
    if (push_first) begin
      entries[wr_ptr] <= first;
    end
    if (push_second) begin
      entries[wr_ptr_second] <= push.part;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pixel_wire_packer.sv =====
// ----------------------------------------------------------------------------
// pixel_wire_packer
// XRGB8888 pixel to wire format converter and 64-bit word packer.
// ----------------------------------------------------------------------------
// One pixel is taken per clock while the queue has room. Each pixel is
// encoded (RGB565, B,G,R, R,G,B or the raw four bytes, chosen by
// wire_format) and merged combinationally with the pending bytes; full
// words leave with their 32-bit halves swapped, and at end of frame the
// remaining bytes leave zero-padded, unswapped, with their byte count.
// Results pass through a four-entry queue, so a pixel is accepted while
// up to one result is still waiting downstream; a pixel that pushes two
// results stalls the input behind it. The user must write wire_format
// via cfg_write/cfg_data only while the packer is idle; the block does not
// enforce this. Pending bytes survive a format change within a frame.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_wire_packer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] pixel,
  input  wire logic        end_of_frame,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      word,
  output logic [3:0]       byte_count,
  output logic             last
);

  logic [1:0]           wire_format_reg;
  logic                 accept;
  logic [31:0]          bytes;
  logic [2:0]           nbytes;
  wpk_pkg::wpk_push_t   push;
  wpk_pkg::wpk_result_t head;

  // Format register
  always_ff @(posedge clk) begin
    if (rst) begin
      wire_format_reg <= wpk_pkg::FMT_RGB565;
    end else if (cfg_write) begin
      wire_format_reg <= cfg_data;
    end
  end

  assign accept = in_valid && in_ready;

  wpk_encode u_encode (
    .pixel       (pixel),
    .wire_format (wire_format_reg),
    .bytes       (bytes),
    .nbytes      (nbytes)
  );

  wpk_pack u_pack (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .bytes        (bytes),
    .nbytes       (nbytes),
    .end_of_frame (end_of_frame),
    .push         (push)
  );

  wpk_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .push      (push),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign word       = head.word;
  assign byte_count = head.byte_count;
  assign last       = head.last;

endmodule

`default_nettype wire

// ===== rtl/wpk_checker.sv =====
// ----------------------------------------------------------------------------
// wpk_checker
// Port-level checks for the pixel wire packer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wpk_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] word,
  input wire logic [3:0]  byte_count,
  input wire logic        last
);

  // Nothing is offered straight after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result offered after reset");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(word) && $stable(byte_count)
      && $stable(last))
    else $error("stalled result changed");

  // Byte count is 1..8, and only the final word may be partial
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_count != 4'd0) && (byte_count <= 4'd8)
      && ((byte_count == 4'd8) || last))
    else $error("bad byte count");

  // Padding of a one-byte partial word is zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    out_valid && (byte_count == 4'd1) |-> (word[63:8] == 56'h0))
    else $error("partial word padding not zero");

endmodule

bind pixel_wire_packer wpk_checker u_wpk_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .word       (word),
  .byte_count (byte_count),
  .last       (last)
);

`default_nettype wire

// ===== bench/tb_pixel_wire_packer.sv =====
// ----------------------------------------------------------------------------
// tb_pixel_wire_packer
// Self-checking bench for the XRGB8888 to wire format word packer.
// ----------------------------------------------------------------------------
// Pixels go in through a valid/ready channel. A scoreboard class keeps its
// own copy of the wire format and the pending bytes, predicts every packed
// word per pixel transfer, and checks each word transfer in order. A directed
// opening covers colour extremes, every format, frame ends on and off a word
// boundary and a format change inside a frame. Random frames follow, with
// bursty idling on both sides and a quiet tail.
// ----------------------------------------------------------------------------

module tb_pixel_wire_packer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PIXEL_TARGET  = 1300;
  localparam int unsigned QUIET_TAIL    = 200;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned REPORT_MAX    = 10;

  // Predicts packed words from pixel transfers and checks word transfers
  class wire_word_board;
    wpk_pkg::wpk_result_t words_due[$];
    logic [1:0]  fmt;
    logic [55:0] held_bytes;
    logic [2:0]  held_count;
    int unsigned faults;

    function new();
      fmt        = wpk_pkg::FMT_RGB565;
      held_bytes = '0;
      held_count = '0;
      faults     = 0;
    endfunction

    function void set_format(input logic [1:0] f);
      fmt = f;
    endfunction

    function int unsigned outstanding();
      return words_due.size();
    endfunction

    // Wire bytes of one pixel, first byte lowest; n gets the byte count
    function logic [31:0] wire_bytes(input logic [31:0] px, output int unsigned n);
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      r = px[23:16];
      g = px[15:8];
      b = px[7:0];
      case (fmt)
        wpk_pkg::FMT_RGB565: begin
          n = 2;
          return {16'h0, r[7:3], g[7:2], b[7:3]};
        end
        wpk_pkg::FMT_BGR: begin
          n = 3;
          return {8'h0, r, g, b};
        end
        wpk_pkg::FMT_RGB: begin
          n = 3;
          return {8'h0, b, g, r};
        end
        default: begin
          n = 4;
          return px;
        end
      endcase
    endfunction

    // Merge one accepted pixel into the pending bytes and queue its words
    function void take_pixel(input logic [31:0] px, input logic eof);
      logic [63:0] v;
      logic [63:0] lo;
      logic [63:0] hi;
      int unsigned n;
      int unsigned c;
      int unsigned total;
      wpk_pkg::wpk_result_t r;
      v     = {32'h0, wire_bytes(px, n)};
      c     = held_count;
      total = c + n;
      lo    = {8'h0, held_bytes} | (v << (8 * c));
      hi    = (c != 0) ? (v >> (64 - 8 * c)) : 64'h0;
      // full word leaves with its halves swapped
      if (total >= 8) begin
        r.word       = {lo[31:0], lo[63:32]};
        r.byte_count = 4'd8;
        r.last       = eof && (total == 8);
        words_due.push_back(r);
        lo    = hi;
        total = total - 8;
      end
      if (total > 0) begin
        lo = lo & ((64'h1 << (8 * total)) - 64'h1);
      end else begin
        lo = '0;
      end
      // frame end flushes the remainder, zero-padded and unswapped
      if (eof) begin
        if (total > 0) begin
          r.word       = lo;
          r.byte_count = total[3:0];
          r.last       = 1'b1;
          words_due.push_back(r);
        end
        held_bytes = '0;
        held_count = '0;
      end else begin
        held_bytes = lo[55:0];
        held_count = total[2:0];
      end
    endfunction

    function void match_word(input logic [63:0] w, input logic [3:0] bc, input logic l);
      wpk_pkg::wpk_result_t e;
      if (words_due.size() == 0) begin
        faults++;
        if (faults <= REPORT_MAX) begin
          $display("%0t: unexpected word %h count %0d last %0b", $realtime, w, bc, l);
        end
        return;
      end
      e = words_due.pop_front();
      if (w !== e.word || bc !== e.byte_count || l !== e.last) begin
        faults++;
        if (faults <= REPORT_MAX) begin
          $display("%0t: word mismatch, expected %h count %0d last %0b,",
                   $realtime, e.word, e.byte_count, e.last);
          $display("    got %h count %0d last %0b", w, bc, l);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] pixel;
  logic        end_of_frame;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] word;
  logic [3:0]  byte_count;
  logic        last;

  wire_word_board board;
  bit             quiet;
  int unsigned    idle_pct;
  int unsigned    sent;
  int unsigned    cycles;

  pixel_wire_packer i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pixel        (pixel),
    .end_of_frame (end_of_frame),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .word         (word),
    .byte_count   (byte_count),
    .last         (last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Transfer monitor: predict on pixel transfers, check on word transfers
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        board.take_pixel(pixel, end_of_frame);
      end
      if (out_valid && out_ready) begin
        board.match_word(word, byte_count, last);
      end
    end
  end

  // Receiver: bursts of back-pressure, none in the quiet tail
  initial begin
    int unsigned run_len;
    forever begin
      out_ready <= 1'b1;
      run_len = ($urandom_range(3) == 0) ? $urandom_range(120, 30) : $urandom_range(12, 1);
      repeat (run_len) @(posedge clk);
      if (!quiet) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(13, 1)) @(posedge clk);
      end
    end
  end

  // One pixel transfer, then maybe an idle burst
  task automatic send_pixel(input logic [31:0] px, input logic eof);
    in_valid     <= 1'b1;
    pixel        <= px;
    end_of_frame <= eof;
    do @(posedge clk); while (!in_ready);
    sent++;
    if (!quiet && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(13, 1)) @(posedge clk);
    end
  endtask

  // Stop sending and wait for every predicted word to come out
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (board.outstanding() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_format(input logic [1:0] f);
    cfg_write <= 1'b1;
    cfg_data  <= f;
    @(posedge clk);
    cfg_write <= 1'b0;
    board.set_format(f);
  endtask

  function automatic logic [31:0] random_pixel();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // One frame; optionally the format is changed partway through
  task automatic send_frame(input int unsigned len, input bit switch_mid);
    int unsigned i;
    int unsigned cut;
    cut = $urandom_range(len - 1, 0);
    for (i = 0; i < len; i++) begin
      if (switch_mid && i == cut && i != 0) begin
        settle();
        write_format($urandom_range(3));
      end
      send_pixel(random_pixel(), i == len - 1);
    end
  endtask

  initial begin
    int unsigned target;
    int unsigned phase;
    int unsigned frames;
    int unsigned len;
    board        = new();
    quiet        = 1'b0;
    idle_pct     = 0;
    sent         = 0;
    rst          <= 1'b1;
    cfg_write    <= 1'b0;
    cfg_data     <= wpk_pkg::FMT_RGB565;
    in_valid     <= 1'b0;
    pixel        <= '0;
    end_of_frame <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset format: white pixel alone, a 2-byte partial word
    send_pixel(32'hFFFF_FFFF, 1'b1);
    // four RGB565 pixels fill a word exactly at frame end
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'h00F8_0000, 1'b0);
    send_pixel(32'h0000_FC00, 1'b0);
    send_pixel(32'h0000_00F8, 1'b1);
    settle();

    // B,G,R: nine bytes, a full word and a 1-byte remainder
    write_format(wpk_pkg::FMT_BGR);
    send_pixel(32'h0012_3456, 1'b0);
    send_pixel(32'hAB01_0203, 1'b0);
    send_pixel(32'h00FF_FFFF, 1'b1);
    settle();

    // R,G,B then a switch to the xrgb copy inside the frame
    write_format(wpk_pkg::FMT_RGB);
    send_pixel(32'h80FF_00AA, 1'b0);
    send_pixel(32'h7F00_FF55, 1'b0);
    settle();
    write_format(wpk_pkg::FMT_XRGB);
    send_pixel(32'hDEAD_BEEF, 1'b0);
    send_pixel(32'h0000_0000, 1'b1);
    // xrgb copy: word boundary at frame end, then a lone pixel
    send_pixel(32'hFFFF_FFFF, 1'b0);
    send_pixel(32'h0102_0304, 1'b1);
    send_pixel(32'hFF00_FF00, 1'b1);
    settle();
    write_format(wpk_pkg::FMT_RGB565);
    send_pixel(32'h5A5A_A5A5, 1'b1);

    // random phases; each starts from an idle packer with a freshly written format
    target = sent + PIXEL_TARGET;
    phase  = 0;
    while (sent < target) begin
      settle();
      write_format(phase < 4 ? phase[1:0] : 2'($urandom_range(3)));
      case ($urandom_range(2))
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        default: idle_pct = 35;
      endcase
      frames = $urandom_range(8, 1);
      repeat (frames) begin
        if (sent < target) begin
          if (target - sent < QUIET_TAIL) begin
            quiet = 1'b1;
          end
          len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
          send_frame(len, $urandom_range(7) == 0);
        end
      end
      phase++;
    end
    settle();

    if (board.faults == 0 && board.outstanding() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
